// File: rtl/bfo_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfo_pkg: shared types and constants for the bearing-from-offset pipeline
// Holds the default port widths, the internal datapath widths, the axis
// direction codes, the per-word side information and the arctangent table.
// ----------------------------------------------------------------------------
package bfo_pkg;

   // Defaults for the top-level parameters.
   localparam int COORD_WIDTH_DEF = 16;
   localparam int ANGLE_WIDTH_DEF = 16;

   // Internal angle resolution: one full turn is 2^TURN_BITS.
   localparam int TURN_BITS    = 32;
   localparam int CORDIC_STEPS = 30;

   // Magnitudes are normalized so the larger one lands on bit NORM_MSB.
   localparam int NORM_MSB     = 54;
   localparam int SHIFT_WIDTH  = 6;
   // Normalized values stay below 2^55; CORDIC gain adds under one bit.
   localparam int XY_WIDTH     = 58;
   // Accumulated angle: the table sum stays well inside 2^31.
   localparam int Z_WIDTH      = 34;

   // Axis directions, numbered in quarter turns clockwise from up.
   typedef enum logic [1:0] {
      DIR_UP    = 2'd0,
      DIR_RIGHT = 2'd1,
      DIR_DOWN  = 2'd2,
      DIR_LEFT  = 2'd3
   } axis_dir_type;

   // Side information that travels with each word down the pipeline.
   typedef struct packed {
      logic         axis;   // offset lies on an axis or at the origin
      axis_dir_type dir;    // direction when on an axis
      logic         neg_x;  // offset_x is negative
      logic         neg_y;  // offset_y is negative
   } side_type;

   // atan(2^-step) as a fraction of a turn, scaled by 2^TURN_BITS.
   function automatic logic [TURN_BITS-1:0] atan_turn(input int step);
      logic [TURN_BITS-1:0] val;
      unique case (step)
         0:  val = 32'h20000000;
         1:  val = 32'h12E4051E;
         2:  val = 32'h09FB385B;
         3:  val = 32'h051111D4;
         4:  val = 32'h028B0D43;
         5:  val = 32'h0145D7E1;
         6:  val = 32'h00A2F61E;
         7:  val = 32'h00517C55;
         8:  val = 32'h0028BE53;
         9:  val = 32'h00145F2F;
         10: val = 32'h000A2F98;
         11: val = 32'h000517CC;
         12: val = 32'h00028BE6;
         13: val = 32'h000145F3;
         14: val = 32'h0000A2FA;
         15: val = 32'h0000517D;
         16: val = 32'h000028BE;
         17: val = 32'h0000145F;
         18: val = 32'h00000A30;
         19: val = 32'h00000518;
         20: val = 32'h0000028C;
         21: val = 32'h00000146;
         22: val = 32'h000000A3;
         23: val = 32'h00000051;
         24: val = 32'h00000029;
         25: val = 32'h00000014;
         26: val = 32'h0000000A;
         27: val = 32'h00000005;
         28: val = 32'h00000003;
         29: val = 32'h00000001;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

// File: rtl/bfo_cordic_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfo_cordic_stage: one registered CORDIC vectoring step
// Rotates (x, y) toward the positive x axis by atan(2^-STEP) and accumulates
// the rotation angle; side information rides along unchanged.
// ----------------------------------------------------------------------------
module bfo_cordic_stage #(
   parameter int STEP = 0
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  enable,
   input  wire logic                                  in_valid,
   input  wire logic signed [bfo_pkg::XY_WIDTH-1:0]   in_x,
   input  wire logic signed [bfo_pkg::XY_WIDTH-1:0]   in_y,
   input  wire logic signed [bfo_pkg::Z_WIDTH-1:0]    in_z,
   input  wire bfo_pkg::side_type                     in_side,
   output logic                                       out_valid,
   output logic signed [bfo_pkg::XY_WIDTH-1:0]        out_x,
   output logic signed [bfo_pkg::XY_WIDTH-1:0]        out_y,
   output logic signed [bfo_pkg::Z_WIDTH-1:0]         out_z,
   output bfo_pkg::side_type                          out_side
);
   import bfo_pkg::*;

   localparam logic [TURN_BITS-1:0] ATAN_RAW = atan_turn(STEP);
   localparam logic signed [Z_WIDTH-1:0] ATAN_STEP =
      {{(Z_WIDTH-TURN_BITS){1'b0}}, ATAN_RAW};

   logic                       valid_ff, valid_in;
   logic signed [XY_WIDTH-1:0] x_ff, x_in;
   logic signed [XY_WIDTH-1:0] y_ff, y_in;
   logic signed [Z_WIDTH-1:0]  z_ff, z_in;
   side_type                   side_ff;
   logic signed [XY_WIDTH-1:0] x_shr;
   logic signed [XY_WIDTH-1:0] y_shr;

   // Arithmetic shifts round toward minus infinity, as the step requires.
   assign x_shr = in_x >>> STEP;
   assign y_shr = in_y >>> STEP;

   always_comb begin
      valid_in = in_valid;
      if (!in_y[XY_WIDTH-1]) begin
         x_in = in_x + y_shr;
         y_in = in_y - x_shr;
         z_in = in_z + ATAN_STEP;
      end else begin
         x_in = in_x - y_shr;
         y_in = in_y + x_shr;
         z_in = in_z - ATAN_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_side  = side_ff;

endmodule

`default_nettype wire

// File: rtl/bearing_from_offset_top.sv
`default_nettype none
// Pipeline: 35 register stages, A, B, C, the CORDIC steps, D and the output
// register; a result word passes through them in that order to rsp_valid.
// Throughput: one word per clock from the unrolled 30-step CORDIC pipeline;
// a stalled result holds the pipeline only once a finished word is queued
// behind it in the last stage. Reset is synchronous and clears valid bits.
// ----------------------------------------------------------------------------
// bearing_from_offset_top: compass bearing of a screen-space offset
// Turns a signed (x, y) offset, y growing downward, into the clockwise angle
// from straight up as an unsigned fraction of a full turn.
// ----------------------------------------------------------------------------
module bearing_from_offset_top #(
   parameter int COORD_WIDTH = bfo_pkg::COORD_WIDTH_DEF,
   parameter int ANGLE_WIDTH = bfo_pkg::ANGLE_WIDTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic signed [COORD_WIDTH-1:0] req_offset_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_offset_y,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [ANGLE_WIDTH-1:0]             rsp_bearing
);
   import bfo_pkg::*;

   // The pipeline moves as a whole. It halts only when the last stage holds
   // a finished word and the output register is full and stalled, so input
   // words keep flowing in while a result waits to be taken.
   logic out_free;
   logic pipe_enable;

   // ---------------------------------------------------------------------
   // Stage A: classify the offset and take magnitudes.
   // ---------------------------------------------------------------------
   logic                   a_valid_ff, a_valid_in;
   logic [COORD_WIDTH-1:0] a_mag_x_ff, a_mag_x_in;
   logic [COORD_WIDTH-1:0] a_mag_y_ff, a_mag_y_in;
   logic [COORD_WIDTH-1:0] a_max_ff, a_max_in;
   side_type               a_side_ff, a_side_in;

   logic x_zero, y_zero;

   always_comb begin
      x_zero          = (req_offset_x == '0);
      y_zero          = (req_offset_y == '0);
      a_valid_in      = req_valid;
      a_side_in.neg_x = req_offset_x[COORD_WIDTH-1];
      a_side_in.neg_y = req_offset_y[COORD_WIDTH-1];
      a_side_in.axis  = x_zero || y_zero;
      // Up and the origin both map to a bearing of zero.
      if (y_zero) begin
         if (x_zero) begin
            a_side_in.dir = DIR_UP;
         end else if (req_offset_x[COORD_WIDTH-1]) begin
            a_side_in.dir = DIR_LEFT;
         end else begin
            a_side_in.dir = DIR_RIGHT;
         end
      end else if (req_offset_y[COORD_WIDTH-1]) begin
         a_side_in.dir = DIR_UP;
      end else begin
         a_side_in.dir = DIR_DOWN;
      end
      // The most negative input becomes 2^(COORD_WIDTH-1), which still fits.
      a_mag_x_in = req_offset_x[COORD_WIDTH-1] ? COORD_WIDTH'(-req_offset_x)
                                               : COORD_WIDTH'(req_offset_x);
      a_mag_y_in = req_offset_y[COORD_WIDTH-1] ? COORD_WIDTH'(-req_offset_y)
                                               : COORD_WIDTH'(req_offset_y);
      a_max_in   = (a_mag_x_in > a_mag_y_in) ? a_mag_x_in : a_mag_y_in;
   end

   // ---------------------------------------------------------------------
   // Stage B: find the normalizing shift from the leading one of the max.
   // ---------------------------------------------------------------------
   logic                   b_valid_ff;
   logic [COORD_WIDTH-1:0] b_mag_x_ff;
   logic [COORD_WIDTH-1:0] b_mag_y_ff;
   logic [SHIFT_WIDTH-1:0] b_shift_ff, b_shift_in;
   side_type               b_side_ff;

   logic [SHIFT_WIDTH-1:0] msb_pos;

   always_comb begin
      msb_pos = '0;
      for (int i = 0; i < COORD_WIDTH; i++) begin
         if (a_max_ff[i]) begin
            msb_pos = SHIFT_WIDTH'(i);
         end
      end
      b_shift_in = SHIFT_WIDTH'(NORM_MSB) - msb_pos;
   end

   // ---------------------------------------------------------------------
   // Stage C: shift both magnitudes so the larger reaches bit NORM_MSB.
   // The CORDIC starts from x = |offset_y| and y = |offset_x|.
   // ---------------------------------------------------------------------
   logic                       x_pipe_valid [0:CORDIC_STEPS];
   logic signed [XY_WIDTH-1:0] x_pipe       [0:CORDIC_STEPS];
   logic signed [XY_WIDTH-1:0] y_pipe       [0:CORDIC_STEPS];
   logic signed [Z_WIDTH-1:0]  z_pipe       [0:CORDIC_STEPS];
   side_type                   side_pipe    [0:CORDIC_STEPS];

   logic                       c_valid_ff;
   logic signed [XY_WIDTH-1:0] c_x_ff, c_x_in;
   logic signed [XY_WIDTH-1:0] c_y_ff, c_y_in;
   side_type                   c_side_ff;

   always_comb begin
      c_x_in = signed'(XY_WIDTH'(b_mag_y_ff) << b_shift_ff);
      c_y_in = signed'(XY_WIDTH'(b_mag_x_ff) << b_shift_ff);
   end

   assign x_pipe_valid[0] = c_valid_ff;
   assign x_pipe[0]       = c_x_ff;
   assign y_pipe[0]       = c_y_ff;
   assign z_pipe[0]       = '0;
   assign side_pipe[0]    = c_side_ff;

   // ---------------------------------------------------------------------
   // CORDIC vectoring steps, one register stage each.
   // ---------------------------------------------------------------------
   for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_step
      bfo_cordic_stage #(
         .STEP (s)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .enable    (pipe_enable),
         .in_valid  (x_pipe_valid[s]),
         .in_x      (x_pipe[s]),
         .in_y      (y_pipe[s]),
         .in_z      (z_pipe[s]),
         .in_side   (side_pipe[s]),
         .out_valid (x_pipe_valid[s+1]),
         .out_x     (x_pipe[s+1]),
         .out_y     (y_pipe[s+1]),
         .out_z     (z_pipe[s+1]),
         .out_side  (side_pipe[s+1])
      );
   end

   // ---------------------------------------------------------------------
   // Stage D: clamp the quadrant angle and place it in the right quadrant.
   // Axis cases take their exact quarter-turn value instead.
   // ---------------------------------------------------------------------
   localparam logic [TURN_BITS:0] FULL_TURN = (TURN_BITS+1)'(1) << TURN_BITS;
   localparam logic [TURN_BITS:0] HALF_TURN = (TURN_BITS+1)'(1) << (TURN_BITS-1);
   localparam logic signed [Z_WIDTH-1:0] QUARTER_Z =
      Z_WIDTH'(1) << (TURN_BITS-2);

   logic                 d_valid_ff;
   logic [TURN_BITS:0]   d_angle_ff, d_angle_in;
   logic signed [Z_WIDTH-1:0] z_last;
   side_type             side_last;
   logic [TURN_BITS:0]   phi;

   assign z_last    = z_pipe[CORDIC_STEPS];
   assign side_last = side_pipe[CORDIC_STEPS];

   always_comb begin
      if (z_last[Z_WIDTH-1]) begin
         phi = '0;
      end else if (z_last > QUARTER_Z) begin
         phi = (TURN_BITS+1)'(QUARTER_Z);
      end else begin
         phi = (TURN_BITS+1)'(z_last);
      end

      if (side_last.axis) begin
         d_angle_in = {1'b0, side_last.dir, {(TURN_BITS-2){1'b0}}};
      end else if (side_last.neg_y) begin
         d_angle_in = side_last.neg_x ? (FULL_TURN - phi) : phi;
      end else begin
         d_angle_in = side_last.neg_x ? (HALF_TURN + phi) : (HALF_TURN - phi);
      end
   end

   // ---------------------------------------------------------------------
   // Output register: round to ANGLE_WIDTH bits, half up; a full turn wraps
   // to zero because only the low ANGLE_WIDTH bits are kept.
   // ---------------------------------------------------------------------
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ANGLE_WIDTH-1:0] rsp_bearing_ff, rsp_bearing_in;

   if (ANGLE_WIDTH < TURN_BITS) begin : g_round
      localparam int RND_SHIFT = TURN_BITS - ANGLE_WIDTH;
      logic [TURN_BITS+1:0] rounded;
      assign rounded = {1'b0, d_angle_ff} + ((TURN_BITS+2)'(1) << (RND_SHIFT-1));
      assign rsp_bearing_in = rounded[RND_SHIFT +: ANGLE_WIDTH];
   end else begin : g_exact
      assign rsp_bearing_in = d_angle_ff[ANGLE_WIDTH-1:0];
   end

   // ---------------------------------------------------------------------
   // Flow control.
   // ---------------------------------------------------------------------
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign pipe_enable  = !d_valid_ff || out_free;
   assign req_stall    = !pipe_enable;
   assign rsp_valid_in = out_free ? d_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pipe_enable) begin
            a_valid_ff <= a_valid_in;
            b_valid_ff <= a_valid_ff;
            c_valid_ff <= b_valid_ff;
            d_valid_ff <= x_pipe_valid[CORDIC_STEPS];
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_enable) begin
         a_mag_x_ff <= a_mag_x_in;
         a_mag_y_ff <= a_mag_y_in;
         a_max_ff   <= a_max_in;
         a_side_ff  <= a_side_in;
         b_mag_x_ff <= a_mag_x_ff;
         b_mag_y_ff <= a_mag_y_ff;
         b_shift_ff <= b_shift_in;
         b_side_ff  <= a_side_ff;
         c_x_ff     <= c_x_in;
         c_y_ff     <= c_y_in;
         c_side_ff  <= b_side_ff;
         d_angle_ff <= d_angle_in;
      end
      if (out_free && d_valid_ff) begin
         rsp_bearing_ff <= rsp_bearing_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_bearing = rsp_bearing_ff;

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------

   // The input is held back only when a finished word is queued behind a
   // stalled result.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (d_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled without a blocked result");

   // A held pipeline keeps its last finished word intact.
   a_hold_last: assert property (@(posedge clock) disable iff (reset)
      !pipe_enable |=> (d_valid_ff && $stable(d_angle_ff)))
      else $error("last stage word changed while held");

   // A new result only comes from a word that sat in the last stage.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(d_valid_ff))
      else $error("result appeared without a finished word");

   // The CORDIC x value stays positive off the axes; a sign flip means the
   // datapath overflowed.
   a_x_positive: assert property (@(posedge clock) disable iff (reset)
      (x_pipe_valid[CORDIC_STEPS] && !side_last.axis)
         |-> !x_pipe[CORDIC_STEPS][XY_WIDTH-1])
      else $error("CORDIC x went negative");

endmodule

`default_nettype wire
